/* src/cxy_pkg.sv */
`default_nettype none
package cxy_pkg;

  localparam int NUM_DOCKS = 5;
  localparam int OUT_DOCKS = 5;

  localparam int POS_W = 24;
  localparam int LIM_W = 23;

  localparam int SENSE_MARGIN_MM = 1;
  localparam int Y_FRONT_OFFSET_MM = 10;
  localparam int X_LEFT_OFFSET_MM = 8;
  localparam int DOCK_X_BASE_MM = X_LEFT_OFFSET_MM + 25;
  localparam int DOCK_PITCH_MM = 82;
  localparam int DOCK_Y_MM = 455 + Y_FRONT_OFFSET_MM;
  localparam int DOCK_MIN_Y_MM = 445;
  localparam int UM_PER_MM = 1000;
  localparam int WINDOW_UM = (SENSE_MARGIN_MM + 1) * UM_PER_MM;

  localparam logic [LIM_W-1:0] X_LIMIT_RST = 23'd375000;
  localparam logic [LIM_W-1:0] Y_LIMIT_RST = 23'd466000;
  localparam logic signed [POS_W-1:0] LAST_X_RST =
    POS_W'((375000 / UM_PER_MM / 2) * UM_PER_MM);
  localparam logic signed [POS_W-1:0] LAST_Y_RST =
    POS_W'((466000 / UM_PER_MM / 2) * UM_PER_MM);
  localparam logic signed [POS_W-1:0] DOCK_MIN_Y_UM = POS_W'(DOCK_MIN_Y_MM * UM_PER_MM);
  localparam logic signed [POS_W:0] DOCK_Y_UM = (POS_W+1)'(DOCK_Y_MM * UM_PER_MM);

  typedef enum logic [1:0] {
    ST_LOST     = 2'd0,
    ST_PARKED   = 2'd1,
    ST_PICKED   = 2'd2,
    ST_CHANGING = 2'd3
  } dock_st_t;

  typedef enum logic [1:0] {
    CFG_X_LIMIT = 2'd0,
    CFG_Y_LIMIT = 2'd1,
    CFG_SWAP    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                    motor_select;
    logic signed [POS_W-1:0] motor_pos_um;
  } cxy_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_um;
    logic signed [POS_W-1:0] y_um;
    logic                    stall_x;
    logic                    stall_y;
    logic                    endstop_write;
    logic                    endstop_level;
    logic [OUT_DOCKS-1:0]    tool_update_mask;
    logic [1:0]              tool_state_0;
    logic [1:0]              tool_state_1;
    logic [1:0]              tool_state_2;
    logic [1:0]              tool_state_3;
    logic [1:0]              tool_state_4;
  } cxy_out_t;

  // Dock X center in um
  function automatic logic signed [POS_W:0] dock_x_um(input int idx);
    return (POS_W+1)'((DOCK_X_BASE_MM + DOCK_PITCH_MM * idx) * UM_PER_MM);
  endfunction

  // True when pos lies strictly inside the window around center
  function automatic logic in_window(input logic signed [POS_W-1:0] pos,
                                     input logic signed [POS_W:0] center);
    logic signed [POS_W:0] diff;
    diff = {pos[POS_W-1], pos} - center;
    return (diff > -(POS_W+1)'(WINDOW_UM)) && (diff < (POS_W+1)'(WINDOW_UM));
  endfunction

endpackage
`default_nettype wire

/* src/cxy_in_if.sv */
`default_nettype none
interface cxy_in_if;
  logic             valid;
  logic             ready;
  cxy_pkg::cxy_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/cxy_out_if.sv */
`default_nettype none
interface cxy_out_if;
  logic              valid;
  logic              ready;
  cxy_pkg::cxy_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/corexy_position_and_dock_tracker_core.sv */
// Pipeline: an accepted transaction goes into the input register, then into
//   the result register, from which the output side takes it.
// Throughput: one transaction per cycle; the input register and the result
//   register each hand on every cycle the result side is not stalled.
// Reset: synchronous, active-low rst_n clears both valid flags, sets motors
//   to zero, last position to half the default limits, docks to parked and
//   the limit and swap registers to their defaults.
`default_nettype none
module corexy_position_and_dock_tracker_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  cxy_in_if.sink                           in_chan,
  cxy_out_if.source                        out_chan,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_idx,
  input  wire logic [cxy_pkg::LIM_W-1:0]   cfg_wdata
);
  import cxy_pkg::*;

  // Configuration registers
  logic [LIM_W-1:0] x_limit_r;
  logic [LIM_W-1:0] y_limit_r;
  logic             swap_r;

  // Input register stage
  logic              s1_valid_r;
  logic              s1_sel_r;
  logic signed [POS_W-1:0] s1_pos_r;

  // Tracker state
  logic signed [POS_W-1:0] motor_a_r, motor_a_nxt;
  logic signed [POS_W-1:0] motor_b_r, motor_b_nxt;
  logic signed [POS_W-1:0] last_x_r;
  logic signed [POS_W-1:0] last_y_r;
  logic                    endstop_r;
  dock_st_t                dock_r   [NUM_DOCKS];
  dock_st_t                dock_nxt [NUM_DOCKS];

  // Result register
  logic     out_valid_r;
  cxy_out_t out_data_r, out_data_nxt;

  logic advance;
  logic fire;

  logic signed [POS_W:0]   sum, dif, sum_adj, dif_adj;
  logic signed [POS_W-1:0] x_raw, y_raw, x_pos, y_pos;
  logic                    stall_x, stall_y, hit;
  logic [NUM_DOCKS-1:0]    upd_mask;
  logic [1:0]              st_out [OUT_DOCKS];

  // The result register frees when empty or being taken; the input register
  // frees when empty or moving on into the result register.
  assign advance       = !out_valid_r || out_chan.ready;
  assign fire          = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // Configuration writes land directly; out-of-range indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RST;
      y_limit_r <= Y_LIMIT_RST;
      swap_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_X_LIMIT: x_limit_r <= cfg_wdata;
        CFG_Y_LIMIT: y_limit_r <= cfg_wdata;
        CFG_SWAP:    swap_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Capture the transaction into the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_sel_r <= in_chan.data.motor_select;
      s1_pos_r <= in_chan.data.motor_pos_um;
    end
  end

  // Kinematics: replace one motor position, then halve the sum and the
  // difference toward zero (add one to a negative value before the shift).
  always_comb begin
    motor_a_nxt = s1_sel_r ? motor_a_r : s1_pos_r;
    motor_b_nxt = s1_sel_r ? s1_pos_r  : motor_b_r;
    sum     = {motor_a_nxt[POS_W-1], motor_a_nxt} + {motor_b_nxt[POS_W-1], motor_b_nxt};
    dif     = {motor_a_nxt[POS_W-1], motor_a_nxt} - {motor_b_nxt[POS_W-1], motor_b_nxt};
    sum_adj = sum + {{POS_W{1'b0}}, sum[POS_W]};
    dif_adj = dif + {{POS_W{1'b0}}, dif[POS_W]};
    x_raw   = sum_adj[POS_W:1];
    y_raw   = dif_adj[POS_W:1];
    x_pos   = swap_r ? y_raw : x_raw;
    y_pos   = swap_r ? x_raw : y_raw;
  end

  // Stall: past the upper limit and still growing, or negative and still
  // shrinking. An axis that did not move never stalls. The limit compare is
  // signed, so a negative position never counts as past the limit.
  always_comb begin
    stall_x = (($signed({x_pos[POS_W-1], x_pos}) > $signed({2'b00, x_limit_r}))
               && (x_pos > last_x_r))
           || (x_pos[POS_W-1] && (x_pos < last_x_r));
    stall_y = (($signed({y_pos[POS_W-1], y_pos}) > $signed({2'b00, y_limit_r}))
               && (y_pos > last_y_r))
           || (y_pos[POS_W-1] && (y_pos < last_y_r));
    hit     = stall_x || stall_y;
  end

  // Dock tracking: visit docks in order; a later dock sees what an earlier
  // one changed. Entering a dock window parks every other dock.
  always_comb begin
    logic yin;
    logic xin;
    for (int i = 0; i < NUM_DOCKS; i++) begin
      dock_nxt[i] = dock_r[i];
    end
    upd_mask = '0;
    xin = 1'b0;
    yin = in_window(y_pos, DOCK_Y_UM);
    if (y_pos >= DOCK_MIN_Y_UM) begin
      for (int i = 0; i < NUM_DOCKS; i++) begin
        xin = in_window(x_pos, dock_x_um(i));
        if (xin && yin) begin
          if (dock_nxt[i] != ST_CHANGING) begin
            for (int j = 0; j < NUM_DOCKS; j++) begin
              if (j == i) begin
                dock_nxt[j] = ST_CHANGING;
              end else begin
                dock_nxt[j] = ST_PARKED;
              end
            end
            upd_mask = '1;
          end
        end else if (dock_nxt[i] == ST_CHANGING) begin
          if (xin) begin
            dock_nxt[i] = ST_PARKED;
            upd_mask[i] = 1'b1;
          end else if (yin) begin
            dock_nxt[i] = ST_PICKED;
            upd_mask[i] = 1'b1;
          end
        end
      end
    end
  end

  // Map tracked docks onto the five output fields; missing docks read zero.
  for (genvar g = 0; g < OUT_DOCKS; g++) begin : g_st_out
    if (g < NUM_DOCKS) begin : g_used
      assign st_out[g] = dock_nxt[g];
    end else begin : g_unused
      assign st_out[g] = 2'b00;
    end
  end

  always_comb begin
    out_data_nxt.x_um             = x_pos;
    out_data_nxt.y_um             = y_pos;
    out_data_nxt.stall_x          = stall_x;
    out_data_nxt.stall_y          = stall_y;
    // Drive the endstop while stalled and once more on the clearing item.
    out_data_nxt.endstop_write    = hit || endstop_r;
    out_data_nxt.endstop_level    = hit;
    out_data_nxt.tool_update_mask = OUT_DOCKS'(upd_mask);
    out_data_nxt.tool_state_0     = st_out[0];
    out_data_nxt.tool_state_1     = st_out[1];
    out_data_nxt.tool_state_2     = st_out[2];
    out_data_nxt.tool_state_3     = st_out[3];
    out_data_nxt.tool_state_4     = st_out[4];
  end

  // Advance tracker state only when the transaction moves into the result
  // register, so a stalled output never double-counts an item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_a_r <= '0;
      motor_b_r <= '0;
      last_x_r  <= LAST_X_RST;
      last_y_r  <= LAST_Y_RST;
      endstop_r <= 1'b0;
      for (int i = 0; i < NUM_DOCKS; i++) begin
        dock_r[i] <= ST_PARKED;
      end
    end else if (fire) begin
      motor_a_r <= motor_a_nxt;
      motor_b_r <= motor_b_nxt;
      last_x_r  <= x_pos;
      last_y_r  <= y_pos;
      endstop_r <= hit;
      for (int i = 0; i < NUM_DOCKS; i++) begin
        dock_r[i] <= dock_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/cxy_checker.sv */
`default_nettype none
module cxy_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire cxy_pkg::cxy_out_t out_data
);
  import cxy_pkg::*;

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Drive the endstop whenever stalled, at the stall level.
  a_endstop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.endstop_level == (out_data.stall_x || out_data.stall_y))
                  && (!out_data.endstop_level || out_data.endstop_write))
    else $error("endstop level or write inconsistent with stall flags");

  // Never report more than one dock changing.
  a_one_changing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.tool_state_0 == ST_CHANGING,
                              out_data.tool_state_1 == ST_CHANGING,
                              out_data.tool_state_2 == ST_CHANGING,
                              out_data.tool_state_3 == ST_CHANGING,
                              out_data.tool_state_4 == ST_CHANGING}) <= 1)
    else $error("more than one dock changing");

  // Come out of reset with no result pending.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind corexy_position_and_dock_tracker_core cxy_checker u_cxy_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cxy_pkg::*;

  // Motor codes on the input channel, and a register index the block must ignore
  localparam logic       MOTOR_A    = 1'b0;
  localparam logic       MOTOR_B    = 1'b1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int POS_MAX     = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN     = -(2 ** (POS_W - 1));
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic     sel;
    int       pos;
    bit       typed;
    cxy_out_t want;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_idx;
  logic [LIM_W-1:0]  cfg_wdata;

  cxy_in_if  in_if ();
  cxy_out_if out_if ();

  corexy_position_and_dock_tracker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Tracker state as the block should hold it
  int       motor_a;
  int       motor_b;
  int       last_x;
  int       last_y;
  bit       endstop_on;
  dock_st_t dock_st [NUM_DOCKS];
  int       x_limit;
  int       y_limit;
  bit       swap_xy;

  // Results owed by the block, oldest first
  cxy_out_t due_results [$];
  int       mismatches;

  // calm: no idling on either side; hold_req: ask the sink for a long stall
  bit calm;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #3ms;
    $display("Verification failed");
    $finish;
  end

  function automatic void reset_tracker();
    motor_a    = 0;
    motor_b    = 0;
    last_x     = 187000;
    last_y     = 233000;
    endstop_on = 1'b0;
    foreach (dock_st[i]) dock_st[i] = ST_PARKED;
    x_limit    = 375000;
    y_limit    = 466000;
    swap_xy    = 1'b0;
  endfunction

  function automatic void apply_cfg(input logic [1:0] idx, input logic [LIM_W-1:0] v);
    case (idx)
      CFG_X_LIMIT: x_limit = int'(v);
      CFG_Y_LIMIT: y_limit = int'(v);
      CFG_SWAP:    swap_xy = v[0];
      default: ;
    endcase
  endfunction

  // Position within the magnet sense window of a dock coordinate
  function automatic bit near_dock(input int pos, input int center);
    int d;
    d = pos - center;
    return d > -WINDOW_UM && d < WINDOW_UM;
  endfunction

  // Advance the tracker by one motor update and return the result it owes
  function automatic cxy_out_t track_move(input logic sel,
                                          input logic signed [POS_W-1:0] pos);
    cxy_out_t    r;
    int          x;
    int          y;
    int          t;
    int          dx;
    int          dy;
    bit          sx;
    bit          sy;
    bit          hit;
    bit          drive;
    bit          xin;
    bit          yin;
    logic [31:0] driven;
    logic [1:0]  shown [OUT_DOCKS];

    if (sel == MOTOR_B) motor_b = pos;
    else motor_a = pos;
    x = (motor_a + motor_b) / 2;
    y = (motor_a - motor_b) / 2;
    if (swap_xy) begin
      t = x;
      x = y;
      y = t;
    end
    dx = x - last_x;
    dy = y - last_y;
    last_x = x;
    last_y = y;

    // Dock tracking only runs high enough in Y; visit docks in order
    driven = '0;
    if (y >= DOCK_MIN_Y_MM * UM_PER_MM) begin
      yin = near_dock(y, DOCK_Y_MM * UM_PER_MM);
      for (int i = 0; i < NUM_DOCKS; i++) begin
        xin = near_dock(x, (DOCK_X_BASE_MM + DOCK_PITCH_MM * i) * UM_PER_MM);
        if (xin && yin) begin
          if (dock_st[i] != ST_CHANGING) begin
            foreach (dock_st[j]) begin
              if (j == i) dock_st[j] = ST_CHANGING;
              else dock_st[j] = ST_PARKED;
              driven[j] = 1'b1;
            end
          end
        end else if (dock_st[i] == ST_CHANGING) begin
          if (xin) begin
            dock_st[i] = ST_PARKED;
            driven[i] = 1'b1;
          end else if (yin) begin
            dock_st[i] = ST_PICKED;
            driven[i] = 1'b1;
          end
        end
      end
    end

    // Stall only when past a bound and still moving outward
    sx = (x > x_limit && dx > 0) || (x < 0 && dx < 0);
    sy = (y > y_limit && dy > 0) || (y < 0 && dy < 0);
    hit = sx || sy;
    drive = hit || endstop_on;
    if (drive) endstop_on = hit;

    for (int i = 0; i < OUT_DOCKS; i++) begin
      shown[i] = (i < NUM_DOCKS) ? 2'(dock_st[i]) : 2'(ST_LOST);
    end
    r.x_um             = x[POS_W-1:0];
    r.y_um             = y[POS_W-1:0];
    r.stall_x          = sx;
    r.stall_y          = sy;
    r.endstop_write    = drive;
    r.endstop_level    = drive && hit;
    r.tool_update_mask = driven[OUT_DOCKS-1:0];
    r.tool_state_0     = shown[0];
    r.tool_state_1     = shown[1];
    r.tool_state_2     = shown[2];
    r.tool_state_3     = shown[3];
    r.tool_state_4     = shown[4];
    return r;
  endfunction

  // Result with no dock activity and every dock parked
  function automatic cxy_out_t parked_out(input int x, input int y, input bit sx,
                                          input bit sy, input bit wr, input bit lvl);
    cxy_out_t r;
    r.x_um             = x[POS_W-1:0];
    r.y_um             = y[POS_W-1:0];
    r.stall_x          = sx;
    r.stall_y          = sy;
    r.endstop_write    = wr;
    r.endstop_level    = lvl;
    r.tool_update_mask = '0;
    r.tool_state_0     = ST_PARKED;
    r.tool_state_1     = ST_PARKED;
    r.tool_state_2     = ST_PARKED;
    r.tool_state_3     = ST_PARKED;
    r.tool_state_4     = ST_PARKED;
    return r;
  endfunction

  function automatic string show(input cxy_out_t r);
    return $sformatf("x=%0d y=%0d stall=%b%b endstop=%b/%b mask=%b docks=%0d%0d%0d%0d%0d",
                     r.x_um, r.y_um, r.stall_x, r.stall_y, r.endstop_write,
                     r.endstop_level, r.tool_update_mask, r.tool_state_0,
                     r.tool_state_1, r.tool_state_2, r.tool_state_3, r.tool_state_4);
  endfunction

  function automatic int spread(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_pos(input int v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Offer one motor update; on acceptance record what the block owes.
  // A typed row pushes its own expectation but still advances the tracker.
  task automatic offer_move(input logic sel, input logic signed [POS_W-1:0] pos,
                            input bit typed, input cxy_out_t want);
    cxy_out_t pred;
    while (!calm && $urandom_range(99) < 20) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid             <= 1'b1;
    in_if.data.motor_select <= sel;
    in_if.data.motor_pos_um <= pos;
    do @(posedge clk); while (!in_if.ready);
    pred = track_move(sel, pos);
    due_results.push_back(typed ? want : pred);
  endtask

  // Drive both motors (or just one) toward a target X/Y, honoring the swap
  task automatic steer(input int tx, input int ty, output int n);
    int ta;
    int tb;
    int pick;
    ta = clamp_pos(tx + ty);
    tb = clamp_pos(swap_xy ? ty - tx : tx - ty);
    pick = $urandom_range(3);
    n = 0;
    if (pick == 0 || pick == 2) begin
      offer_move(MOTOR_A, POS_W'(ta), 1'b0, '0);
      n++;
    end
    if (pick != 2) begin
      offer_move(MOTOR_B, POS_W'(tb), 1'b0, '0);
      n++;
    end
    if (pick == 1) begin
      offer_move(MOTOR_A, POS_W'(ta), 1'b0, '0);
      n++;
    end
  endtask

  // Random traffic: mostly dock visits and moves around the travel limits,
  // with small single-motor nudges and raw positions mixed in
  task automatic roam(input int count);
    int sent;
    int kind;
    int k;
    int tx;
    int ty;
    int n;
    logic sel;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        k  = $urandom_range(NUM_DOCKS - 1);
        tx = (DOCK_X_BASE_MM + DOCK_PITCH_MM * k) * UM_PER_MM + spread(-4000, 4000);
        ty = DOCK_Y_MM * UM_PER_MM + spread(-26000, 4000);
        steer(tx, ty, n);
        sent += n;
      end else if (kind < 65) begin
        tx = $urandom_range(1) ? x_limit + spread(-3000, 3000) : spread(-3000, 3000);
        ty = $urandom_range(1) ? y_limit + spread(-3000, 3000) : spread(-3000, 3000);
        steer(tx, ty, n);
        sent += n;
      end else if (kind < 82) begin
        sel = 1'($urandom_range(1));
        tx  = (sel == MOTOR_B) ? motor_b : motor_a;
        offer_move(sel, POS_W'(clamp_pos(tx + spread(-5000, 5000))), 1'b0, '0);
        sent++;
      end else begin
        offer_move(1'($urandom_range(1)), POS_W'($urandom), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Drop the offer, hold the sender until every owed result is back, then
  // let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [LIM_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    apply_cfg(idx, v);
  endtask

  // Write all registers back to back, plus one write to an unused index
  task automatic program_regs(input int xl, input int yl, input bit sw);
    write_reg(CFG_X_LIMIT, LIM_W'(xl));
    write_reg(CFG_Y_LIMIT, LIM_W'(yl));
    write_reg(CFG_SWAP, {(LIM_W-1)'($urandom), sw});
    write_reg(CFG_UNUSED, LIM_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result sink: random back-pressure, plus a long hold on request
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  // Compare every accepted result with the oldest one owed
  always @(posedge clk) begin : result_check
    cxy_out_t want;
    cxy_out_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result: %s", $time, show(got));
      end else begin
        want = due_results.pop_front();
        if (got.x_um !== want.x_um || got.y_um !== want.y_um ||
            got.stall_x !== want.stall_x || got.stall_y !== want.stall_y ||
            got.endstop_write !== want.endstop_write ||
            got.endstop_level !== want.endstop_level ||
            got.tool_update_mask !== want.tool_update_mask ||
            got.tool_state_0 !== want.tool_state_0 ||
            got.tool_state_1 !== want.tool_state_1 ||
            got.tool_state_2 !== want.tool_state_2 ||
            got.tool_state_3 !== want.tool_state_3 ||
            got.tool_state_4 !== want.tool_state_4) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result mismatch", $time);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [];

    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_X_LIMIT;
    cfg_wdata    = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    mismatches   = 0;
    reset_tracker();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk from reset. Typed rows: reset state, full-scale positions
    // on both motors, halving toward zero, stall below zero, endstop clear and
    // an unmoved axis. The rest visit docks 0 and 4: enter, re-enter while
    // changing, leave parked and picked, and drop below the Y gate.
    plan = '{
      '{MOTOR_A, 0,        1'b1, parked_out(0, 0, 0, 0, 0, 0)},
      '{MOTOR_A, 8388607,  1'b1, parked_out(4194303, 4194303, 1, 1, 1, 1)},
      '{MOTOR_A, -8388608, 1'b1, parked_out(-4194304, -4194304, 1, 1, 1, 1)},
      '{MOTOR_B, -8388608, 1'b1, parked_out(-8388608, 0, 1, 0, 1, 1)},
      '{MOTOR_B, 8388607,  1'b1, parked_out(0, -8388607, 0, 1, 1, 1)},
      '{MOTOR_A, 0,        1'b1, parked_out(4194303, -4194303, 1, 0, 1, 1)},
      '{MOTOR_B, 0,        1'b1, parked_out(0, 0, 0, 0, 1, 0)},
      '{MOTOR_B, 0,        1'b1, parked_out(0, 0, 0, 0, 0, 0)},
      '{MOTOR_A, 1000000,  1'b0, '0},
      '{MOTOR_B, 0,        1'b0, '0},
      '{MOTOR_A, 498000,   1'b0, '0},
      '{MOTOR_B, -432000,  1'b0, '0},
      '{MOTOR_B, -432000,  1'b0, '0},
      '{MOTOR_B, -428200,  1'b0, '0},
      '{MOTOR_A, 494200,   1'b0, '0},
      '{MOTOR_A, 498000,   1'b0, '0},
      '{MOTOR_A, 504000,   1'b0, '0},
      '{MOTOR_A, 826000,   1'b0, '0},
      '{MOTOR_B, -104000,  1'b0, '0},
      '{MOTOR_B, -79000,   1'b0, '0},
      '{MOTOR_A, 801000,   1'b0, '0},
      '{MOTOR_B, -104000,  1'b0, '0},
      '{MOTOR_A, 826000,   1'b0, '0}
    };
    foreach (plan[i]) offer_move(plan[i].sel, POS_W'(plan[i].pos), plan[i].typed,
                                 plan[i].want);
    drain();

    // Default limits with the axes swapped
    program_regs(375000, 466000, 1'b1);
    roam(170);
    drain();

    // Zero limits, with no idling on either side for the whole stretch
    program_regs(0, 0, 1'b0);
    calm = 1'b1;
    roam(170);
    calm = 1'b0;
    drain();

    // Full-scale limits; stall the sink while the sender keeps pushing,
    // then pause the sender until everything owed has come back
    program_regs(2 ** LIM_W - 1, 2 ** LIM_W - 1, 1'b1);
    roam(60);
    hold_req = 1'b1;
    roam(50);
    drain();
    roam(60);
    drain();

    program_regs(spread(20000, 600000), spread(20000, 600000), 1'($urandom_range(1)));
    roam(170);
    drain();

    // Back to the reset settings, written explicitly
    program_regs(375000, 466000, 1'b0);
    roam(170);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
src/cxy_pkg.sv
src/cxy_in_if.sv
src/cxy_out_if.sv
src/corexy_position_and_dock_tracker_core.sv
src/cxy_checker.sv
test/testbench.sv
